### rtl/buddy_region_add_and_reserve_unit_macros.svh
// Assertion macros for the buddy region add and reserve unit.
`ifndef BUDDY_REGION_ADD_AND_RESERVE_UNIT_MACROS_SVH
`define BUDDY_REGION_ADD_AND_RESERVE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define BRA_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every clock edge outside reset.
`define BRA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BRA_ASSERT(lbl, ante, cons, msg)
`define BRA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/bra_pkg.sv
// Shared types and constants of the buddy region add and reserve unit.
`timescale 1ns / 1ps
package bra_pkg;
   localparam int ADDR_W  = 29;
   localparam int PFN_W   = 31;
   localparam int LG_W    = 5;
   localparam int OW      = 4;
   localparam int CNT_W   = 17;
   localparam int STAT_W  = 2;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

   localparam logic REQ_ADD     = 1'b0;
   localparam logic REQ_RESERVE = 1'b1;

   localparam logic [1:0] CNT_NOP  = 2'd0;
   localparam logic [1:0] CNT_INC1 = 2'd1;
   localparam logic [1:0] CNT_INC2 = 2'd2;
   localparam logic [1:0] CNT_DEC  = 2'd3;

   typedef struct packed {
      logic [OW-1:0] order;
      logic          head;
   } page_entry_type;

   typedef struct packed {
      logic [1:0]    op;
      logic [OW-1:0] idx;
   } cnt_op_type;
endpackage

### rtl/bra_page_mem.sv
// Page store: per-page order and free-head flag, one write and one registered read port.
`timescale 1ns / 1ps
module bra_page_mem #(
   parameter int PAGE_COUNT_LOG2 = 16
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [PAGE_COUNT_LOG2-1:0]  wr_addr,
   input  bra_pkg::page_entry_type     wr_data,
   input  logic [PAGE_COUNT_LOG2-1:0]  rd_addr,
   output bra_pkg::page_entry_type     rd_data
);
   import bra_pkg::*;

   page_entry_type mem_ff [2**PAGE_COUNT_LOG2];
   page_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/bra_count_file.sv
// Free block counters per order with saturating update and one read index.
`timescale 1ns / 1ps
module bra_count_file #(
   parameter int ORDER_COUNT = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bra_pkg::cnt_op_type            cnt_op,
   output logic [bra_pkg::CNT_W-1:0]      rd_value
);
   import bra_pkg::*;

   localparam int CIW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;

   logic [CNT_W-1:0] cnt_ff [ORDER_COUNT];
   logic [CNT_W-1:0] cur;
   logic [CNT_W-1:0] upd;
   logic [CNT_W:0]   sum;
   logic             hit;

   assign hit = (32'(cnt_op.idx) < ORDER_COUNT);
   assign cur = hit ? cnt_ff[cnt_op.idx[CIW-1:0]] : '0;
   assign rd_value = cur;

   // compute the saturated new count
   always_comb begin
      sum = {1'b0, cur};
      upd = cur;
      unique case (cnt_op.op)
         CNT_INC1: begin
            sum = {1'b0, cur} + (CNT_W+1)'(1);
            upd = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
         end
         CNT_INC2: begin
            sum = {1'b0, cur} + (CNT_W+1)'(2);
            upd = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
         end
         CNT_DEC: begin
            upd = (cur != '0) ? cur - CNT_W'(1) : cur;
         end
         default: begin
            upd = cur;
         end
      endcase
   end

   // hold counts, update one per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ORDER_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (hit && cnt_op.op != CNT_NOP) begin
         cnt_ff[cnt_op.idx[CIW-1:0]] <= upd;
      end
   end
endmodule

### rtl/buddy_region_add_and_reserve_unit.sv
// Top level: request decode, block sequencer and result register of the buddy engine.
//
//   channel | direction | beat contents
//   req_    | in        | req_type, req_range_base, req_range_limit, req_report_order
//   rsp_    | out       | rsp_status, rsp_free_page_total, rsp_order_free_blocks
//
// After reset the page store is swept clear, every page, with req_ready low.
// An add first marks the order of every page, then marks each block head free.
// A reserve, per block, issues the read, walks back over the pages to the enclosing free
// head, splits through S_SPLIT_A and S_SPLIT_B and takes the block; all paced by the page store port.
// Every request is accepted in S_IDLE and reported through S_REPORT and S_RESP; one at a time.
// A result waits in its register until rsp_ready; the next request is taken after.
`timescale 1ns / 1ps
`include "buddy_region_add_and_reserve_unit_macros.svh"
module buddy_region_add_and_reserve_unit #(
   parameter int PAGE_COUNT_LOG2 = 16,
   parameter int ORDER_COUNT     = 11,
   parameter int PAGE_SHIFT      = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [bra_pkg::ADDR_W-1:0]    req_range_base,
   input  logic [bra_pkg::ADDR_W-1:0]    req_range_limit,
   input  logic [bra_pkg::OW-1:0]        req_report_order,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bra_pkg::STAT_W-1:0]    rsp_status,
   output logic [bra_pkg::CNT_W-1:0]     rsp_free_page_total,
   output logic [bra_pkg::CNT_W-1:0]     rsp_order_free_blocks
);
   import bra_pkg::*;

   localparam int PW = PAGE_COUNT_LOG2;
   localparam logic [PFN_W-1:0] NPAGES   = PFN_W'(1) << PAGE_COUNT_LOG2;
   localparam logic [PFN_W-1:0] PG_ROUND = (PFN_W'(1) << PAGE_SHIFT) - PFN_W'(1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_ADD_MARK = 4'd2;
   localparam logic [3:0] S_ADD_HEAD = 4'd3;
   localparam logic [3:0] S_RSV_BLK  = 4'd4;
   localparam logic [3:0] S_WALK     = 4'd5;
   localparam logic [3:0] S_SPLIT_A  = 4'd6;
   localparam logic [3:0] S_SPLIT_B  = 4'd7;
   localparam logic [3:0] S_RSV_END  = 4'd8;
   localparam logic [3:0] S_REPORT   = 4'd9;
   localparam logic [3:0] S_RESP     = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [PFN_W-1:0]  p_ff, p_in;
   logic [PFN_W-1:0]  first_ff, first_in;
   logic [PFN_W-1:0]  endp_ff, endp_in;
   logic [PW-1:0]     head_ff, head_in;
   logic [OW-1:0]     ord_ff, ord_in;
   logic [OW-1:0]     ho_ff, ho_in;
   logic [OW-1:0]     rep_ff, rep_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_total_ff, rsp_total_in;
   logic [CNT_W-1:0]  rsp_blocks_ff, rsp_blocks_in;

   logic              wr_en;
   logic [PW-1:0]     wr_addr;
   page_entry_type    wr_data;
   logic [PW-1:0]     rd_addr;
   page_entry_type    rd_data;
   cnt_op_type        cnt_op;
   logic [CNT_W-1:0]  cnt_value;

   logic [PFN_W-1:0]  base_x, limit_x, dec_first, dec_endp;
   logic              dec_empty;
   logic [OW-1:0]     tz;
   logic              tz_run;
   logic [PFN_W-1:0]  rem;
   logic [LG_W-1:0]   lg;
   logic [OW-1:0]     bo;
   logic [PFN_W-1:0]  p_next;
   logic [PFN_W-1:0]  head_x, step, second, tsum;
   logic [OW-1:0]     ho_dn;

   bra_page_mem #(.PAGE_COUNT_LOG2(PAGE_COUNT_LOG2)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bra_count_file #(.ORDER_COUNT(ORDER_COUNT)) u_cnt (
      .clock    (clock),
      .reset    (reset),
      .cnt_op   (cnt_op),
      .rd_value (cnt_value)
   );

   // decode the byte range of the incoming beat into pages
   always_comb begin
      base_x  = PFN_W'(req_range_base);
      limit_x = PFN_W'(req_range_limit);
      if (req_type == REQ_ADD) begin
         dec_first = (base_x + PG_ROUND) >> PAGE_SHIFT;
         dec_endp  = limit_x >> PAGE_SHIFT;
      end else begin
         dec_first = base_x >> PAGE_SHIFT;
         dec_endp  = (limit_x + PG_ROUND) >> PAGE_SHIFT;
      end
      if (dec_endp > NPAGES) begin
         dec_endp = NPAGES;
      end
      dec_empty = (req_type == REQ_ADD && req_range_base == req_range_limit)
                  || (dec_first >= dec_endp);
   end

   // natural block order at p_ff bounded by the range end
   always_comb begin
      tz     = '0;
      tz_run = 1'b1;
      for (int i = 0; i < ORDER_COUNT - 1; i++) begin
         if (tz_run && !p_ff[i]) begin
            tz = tz + OW'(1);
         end else begin
            tz_run = 1'b0;
         end
      end
      rem = endp_ff - p_ff;
      lg  = '0;
      for (int i = 0; i < PFN_W; i++) begin
         if (rem[i]) begin
            lg = LG_W'(i);
         end
      end
      bo = (lg < LG_W'(tz)) ? lg[OW-1:0] : tz;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      first_in      = first_ff;
      endp_in       = endp_ff;
      head_in       = head_ff;
      ord_in        = ord_ff;
      ho_in         = ho_ff;
      rep_in        = rep_ff;
      status_in     = status_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_blocks_in = rsp_blocks_ff;
      wr_en         = 1'b0;
      wr_addr       = p_ff[PW-1:0];
      wr_data       = '{order: bo, head: 1'b0};
      rd_addr       = head_ff;
      cnt_op        = '{op: CNT_NOP, idx: bo};
      req_ready     = 1'b0;
      p_next        = p_ff + (PFN_W'(1) << bo);
      head_x        = PFN_W'(head_ff);
      step          = PFN_W'(1) << rd_data.order;
      ho_dn         = ho_ff - OW'(1);
      second        = head_x + (PFN_W'(1) << ho_dn);
      tsum          = PFN_W'(total_ff) + (endp_ff - first_ff);
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '{order: '0, head: 1'b0};
            p_in    = p_ff + PFN_W'(1);
            if (p_ff == NPAGES - PFN_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               p_in      = dec_first;
               first_in  = dec_first;
               endp_in   = dec_endp;
               rep_in    = req_report_order;
               status_in = ST_DONE;
               if (dec_empty) begin
                  status_in = ST_EMPTY;
                  state_in  = S_REPORT;
               end else if (req_type == REQ_ADD) begin
                  state_in = S_ADD_MARK;
               end else begin
                  state_in = S_RSV_BLK;
               end
            end
         end
         S_ADD_MARK: begin
            // give each page its natural order, head flag clear
            wr_en = 1'b1;
            p_in  = p_ff + PFN_W'(1);
            if (p_ff + PFN_W'(1) >= endp_ff) begin
               p_in     = first_ff;
               state_in = S_ADD_HEAD;
            end
         end
         S_ADD_HEAD: begin
            // mark block heads free and count them
            wr_en   = 1'b1;
            wr_data = '{order: bo, head: 1'b1};
            cnt_op  = '{op: CNT_INC1, idx: bo};
            p_in    = p_next;
            if (p_next >= endp_ff) begin
               total_in = (tsum > PFN_W'(CNT_MAX)) ? CNT_MAX : tsum[CNT_W-1:0];
               state_in = S_REPORT;
            end
         end
         S_RSV_BLK: begin
            ord_in   = bo;
            head_in  = p_ff[PW-1:0];
            rd_addr  = p_ff[PW-1:0];
            state_in = S_WALK;
         end
         S_WALK: begin
            // walk back to the enclosing free head
            if (!rd_data.head) begin
               if (step > head_x) begin
                  status_in = ST_BAD;
                  state_in  = S_REPORT;
               end else begin
                  head_in = head_ff - step[PW-1:0];
                  rd_addr = head_ff - step[PW-1:0];
               end
            end else begin
               ho_in = rd_data.order;
               if (rd_data.order < ord_ff ||
                   head_x + (PFN_W'(1) << rd_data.order) < p_ff + (PFN_W'(1) << ord_ff)) begin
                  status_in = ST_BAD;
                  state_in  = S_REPORT;
               end else if (rd_data.order == ord_ff) begin
                  state_in = S_RSV_END;
               end else begin
                  state_in = S_SPLIT_A;
               end
            end
         end
         S_SPLIT_A: begin
            // shrink the lower half and drop one block of the split order
            wr_en    = 1'b1;
            wr_addr  = head_ff;
            wr_data  = '{order: ho_dn, head: 1'b1};
            cnt_op   = '{op: CNT_DEC, idx: ho_ff};
            state_in = S_SPLIT_B;
         end
         S_SPLIT_B: begin
            // mark the upper buddy free and advance toward the wanted block
            wr_en   = 1'b1;
            wr_addr = second[PW-1:0];
            wr_data = '{order: ho_dn, head: 1'b1};
            cnt_op  = '{op: CNT_INC2, idx: ho_dn};
            ho_in   = ho_dn;
            if (second <= p_ff) begin
               head_in = second[PW-1:0];
            end
            state_in = (ho_dn == ord_ff) ? S_RSV_END : S_SPLIT_A;
         end
         S_RSV_END: begin
            // take the block off the free set
            wr_en   = 1'b1;
            wr_data = '{order: ord_ff, head: 1'b0};
            cnt_op  = '{op: CNT_DEC, idx: ord_ff};
            p_in    = p_ff + (PFN_W'(1) << ord_ff);
            state_in = (p_ff + (PFN_W'(1) << ord_ff) >= endp_ff) ? S_REPORT : S_RSV_BLK;
         end
         S_REPORT: begin
            cnt_op        = '{op: CNT_NOP, idx: rep_ff};
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_total_in  = total_ff;
            rsp_blocks_in = cnt_value;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         p_ff         <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      endp_ff       <= endp_in;
      head_ff       <= head_in;
      ord_ff        <= ord_in;
      ho_ff         <= ho_in;
      rep_ff        <= rep_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_blocks_ff <= rsp_blocks_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_free_page_total   = rsp_total_ff;
   assign rsp_order_free_blocks = rsp_blocks_ff;

   `BRA_ASSERT(a_busy_when_result, rsp_valid_ff, !req_ready, "ready while result pending")
   `BRA_ASSERT_NXT(a_busy_after_take, req_valid && req_ready, !req_ready, "ready after accept")
   `BRA_ASSERT(a_no_take_in_clear, state_ff == S_CLEAR, !req_ready, "ready during sweep")
   `BRA_ASSERT(a_status_code, rsp_valid_ff, rsp_status != 2'd3, "bad status")
endmodule

### sim/buddy_region_add_and_reserve_checker.sv
// Checker for the buddy engine: page store prediction and result comparison.
`timescale 1ns / 1ps
module buddy_region_add_and_reserve_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_type,
   input  logic [bra_pkg::ADDR_W-1:0] req_range_base,
   input  logic [bra_pkg::ADDR_W-1:0] req_range_limit,
   input  logic [bra_pkg::OW-1:0]     req_report_order,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [bra_pkg::STAT_W-1:0] rsp_status,
   input  logic [bra_pkg::CNT_W-1:0]  rsp_free_page_total,
   input  logic [bra_pkg::CNT_W-1:0]  rsp_order_free_blocks,
   output int                         mismatches,
   output int                         outstanding,
   output int                         seen_done,
   output int                         seen_empty,
   output int                         seen_bad
);
   import bra_pkg::*;

   localparam int PAGE_LG  = 16;
   localparam int ORDERS   = 11;
   localparam int PG_SHIFT = 12;
   localparam longint PAGES = longint'(1) << PAGE_LG;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  total;
      logic [CNT_W-1:0]  blocks;
   } buddy_result_type;

   logic [OW-1:0] page_order [PAGES];
   bit            page_head  [PAGES];
   int unsigned   free_blocks [ORDERS];
   int unsigned   free_pages;
   buddy_result_type expected_results [$];

   function automatic int unsigned sat_sum(int unsigned a, longint b);
      longint s;
      s = longint'(a) + b;
      return (s > longint'(CNT_MAX)) ? int'(CNT_MAX) : int'(s);
   endfunction

   function automatic void blocks_up(int o, int unsigned n);
      if (o < ORDERS) free_blocks[o] = sat_sum(free_blocks[o], n);
   endfunction

   function automatic void blocks_down(int o);
      if (o < ORDERS && free_blocks[o] > 0) free_blocks[o]--;
   endfunction

   // Largest natural order starting at pfn that still ends by endp.
   function automatic int natural_order(longint pfn, longint endp);
      int o;
      o = 0;
      while (o < ORDERS - 1 && ((pfn >> o) & 1) == 0) o++;
      while (o > 0 && pfn + (longint'(1) << o) > endp) o--;
      return o;
   endfunction

   function automatic void add_region(longint first, longint endp);
      longint p;
      for (p = first; p < endp; p++) begin
         page_order[p] = OW'(natural_order(p, endp));
         page_head[p] = 0;
      end
      p = first;
      while (p < endp) begin
         blocks_up(page_order[p], 1);
         page_head[p] = 1;
         p += longint'(1) << page_order[p];
      end
      free_pages = sat_sum(free_pages, endp - first);
   endfunction

   // Carve one aligned block out of its enclosing free block; 0 on bad state.
   function automatic bit carve_block(longint page, int o);
      longint head;
      longint step;
      longint upper;
      int ho;
      head = page;
      while (!page_head[head]) begin
         step = longint'(1) << page_order[head];
         if (step > head) return 0;
         head -= step;
      end
      ho = page_order[head];
      if (ho < o || head + (longint'(1) << ho) < page + (longint'(1) << o)) return 0;
      while (ho != o) begin
         upper = head + (longint'(1) << (ho - 1));
         blocks_down(ho);
         blocks_up(ho - 1, 2);
         page_head[upper & (PAGES - 1)] = 1;
         page_order[upper & (PAGES - 1)] = OW'(ho - 1);
         page_order[head] = OW'(ho - 1);
         if (upper <= page) head = upper;
         ho--;
      end
      blocks_down(o);
      page_head[page] = 0;
      return 1;
   endfunction

   function automatic buddy_result_type apply_request(logic kind, longint base, longint limit,
                                                       int rep);
      longint first;
      longint endp;
      longint p;
      int o;
      buddy_result_type r;
      r.status = ST_DONE;
      if (kind == REQ_ADD) begin
         first = (base + (longint'(1) << PG_SHIFT) - 1) >> PG_SHIFT;
         endp = limit >> PG_SHIFT;
      end else begin
         first = base >> PG_SHIFT;
         endp = (limit + (longint'(1) << PG_SHIFT) - 1) >> PG_SHIFT;
      end
      if (endp > PAGES) endp = PAGES;
      if ((kind == REQ_ADD && base == limit) || first >= endp) begin
         r.status = ST_EMPTY;
      end else if (kind == REQ_ADD) begin
         add_region(first, endp);
      end else begin
         p = first;
         while (p < endp) begin
            o = natural_order(p, endp);
            if (!carve_block(p, o)) begin
               r.status = ST_BAD;
               break;
            end
            p += longint'(1) << o;
         end
      end
      r.total = CNT_W'(free_pages);
      r.blocks = (rep < ORDERS) ? CNT_W'(free_blocks[rep]) : '0;
      return r;
   endfunction

   assign outstanding = expected_results.size();

   // Compare each result beat, then predict each request beat.
   always @(posedge clock) begin
      buddy_result_type want;
      if (reset) begin
         for (int i = 0; i < PAGES; i++) begin
            page_order[i] = '0;
            page_head[i] = 0;
         end
         for (int i = 0; i < ORDERS; i++) free_blocks[i] = 0;
         free_pages = 0;
         expected_results.delete();
         mismatches <= 0;
         seen_done <= 0;
         seen_empty <= 0;
         seen_bad <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result beat with nothing expected: status %0d", $realtime,
                           rsp_status);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.status != rsp_status || want.total != rsp_free_page_total ||
                   want.blocks != rsp_order_free_blocks) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch exp status %0d total %0d blocks %0d, got %0d %0d %0d",
                              $realtime, want.status, want.total, want.blocks, rsp_status,
                              rsp_free_page_total, rsp_order_free_blocks);
                  mismatches <= mismatches + 1;
               end
               case (want.status)
                  ST_DONE:  seen_done <= seen_done + 1;
                  ST_EMPTY: seen_empty <= seen_empty + 1;
                  default:  seen_bad <= seen_bad + 1;
               endcase
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(apply_request(req_type, longint'(req_range_base),
                                                     longint'(req_range_limit),
                                                     int'(req_report_order)));
      end
   end
endmodule

### sim/tb_buddy_region_add_and_reserve_unit.sv
// Testbench top: stimulus, handshake pacing and verdict for the buddy engine.
`timescale 1ns / 1ps
module tb_buddy_region_add_and_reserve_unit;
   import bra_pkg::*;

   localparam int ITEMS      = 1900;
   localparam int IDLE_LIMIT = 1000000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [ADDR_W-1:0]   req_range_base;
   logic [ADDR_W-1:0]   req_range_limit;
   logic [OW-1:0]       req_report_order;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STAT_W-1:0]   rsp_status;
   logic [CNT_W-1:0]    rsp_free_page_total;
   logic [CNT_W-1:0]    rsp_order_free_blocks;
   int                  mismatches;
   int                  outstanding;
   int                  seen_done;
   int                  seen_empty;
   int                  seen_bad;
   int                  idle_cycles;
   int                  sent;

   buddy_region_add_and_reserve_unit uut (.*);

   buddy_region_add_and_reserve_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Pick a gap: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // Drive one request beat and hold it until accepted.
   task automatic send_request(logic kind, longint base, longint limit, int rep);
      int gap;
      req_type <= kind;
      req_range_base <= ADDR_W'(base);
      req_range_limit <= ADDR_W'(limit);
      req_report_order <= OW'(rep);
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Let the last accepted beat reach the checker, then wait for every result.
   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Result side stalls in bursts, with some long stall-free stretches.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 9) == 0 ? 200 : $urandom_range(1, 8)) @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   end

   // Watchdog: end the run if no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      longint region_page;
      longint region_len;
      longint off;
      longint span;
      longint base;
      int rep;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_ADD;
      req_range_base = '0;
      req_range_limit = '0;
      req_report_order = '0;
      idle_cycles = 0;
      sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty ranges, missing heads, whole-store add, splits, clipping.
      send_request(REQ_ADD, 'h3000, 'h3000, 0);
      send_request(REQ_RESERVE, 'h5000, 'h6000, 1);
      send_request(REQ_ADD, 'h1001, 'h9fff, 2);
      send_request(REQ_RESERVE, 'h2000, 'h3000, 0);
      send_request(REQ_ADD, 0, 'h1000_0000, 10);
      send_request(REQ_ADD, 'hfffe000, 'h1fff_ffff, 15);
      send_request(REQ_RESERVE, 0, 1, 0);
      send_request(REQ_RESERVE, 'h3000, 'h5000, 1);
      send_request(REQ_RESERVE, 'h3000, 'h5000, 2);
      send_request(REQ_RESERVE, 'h1000_0000, 'h1fff_ffff, 3);
      send_request(REQ_ADD, 'h9000, 'h4000, 4);
      send_request(REQ_RESERVE, 'h12345, 'h23456, 5);
      send_request(REQ_RESERVE, 'h40001, 'h40001, 6);
      send_request(REQ_RESERVE, 'h80000, 'h100000, 7);
      send_request(REQ_RESERVE, 'h400000, 'h800000, 10);
      send_request(REQ_ADD, 'h400000, 'h800000, 9);
      send_request(REQ_RESERVE, 'hfff_f000, 'h1000_0000, 11);
      send_request(REQ_ADD, 'h1fff_f000, 'h1fff_ffff, 8);
      req_valid <= 1'b0;
      wait_drained();

      // Random: mostly an add of a region followed by reserves inside it.
      region_page = 0;
      region_len = 0;
      while (sent < ITEMS) begin
         rep = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10);
         if ($urandom_range(0, 99) < 10) begin
            base = $urandom_range(0, (1 << ADDR_W) - 1);
            if ($urandom_range(0, 1) == 1 && $urandom_range(0, 3) == 0)
               send_request(REQ_RESERVE, base, $urandom_range(0, (1 << ADDR_W) - 1), rep);
            else
               send_request($urandom_range(0, 1), base,
                            (base + $urandom_range(0, 64 * 4096)) & ((1 << ADDR_W) - 1), rep);
         end else if (region_len == 0 || $urandom_range(0, 99) < 20) begin
            region_len = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 1024)
                                                      : $urandom_range(1, 64);
            region_page = $urandom_range(0, 65536 - 1024);
            base = region_page << 12;
            if ($urandom_range(0, 3) == 0) base += $urandom_range(0, 4095);
            send_request(REQ_ADD, base, (region_page + region_len) << 12, rep);
         end else begin
            off = $urandom_range(0, region_len - 1);
            span = $urandom_range(1, region_len - off);
            base = (region_page + off) << 12;
            if ($urandom_range(0, 4) == 0) base += $urandom_range(0, 4095);
            send_request(REQ_RESERVE, base, (region_page + off + span) << 12, rep);
         end
         // Hold the sender until every result is back, now and then.
         if (sent % 300 == 0) begin
            req_valid <= 1'b0;
            wait_drained();
            repeat ($urandom_range(0, 50)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);

      $display("Sent %0d requests: %0d done, %0d empty, %0d inconsistent free state.",
               sent, seen_done, seen_empty, seen_bad);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
